// ===== rtl/uri_pkg.sv =====
// Shared types and constants for the UART register interface.
// Holds the item and result word structs and the register codes; no dependencies.
`default_nettype none

package uri_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    localparam logic [2:0] OFF_RBR = 3'd0;
    localparam logic [2:0] OFF_IER = 3'd1;
    localparam logic [2:0] OFF_IIR = 3'd2;
    localparam logic [2:0] OFF_LCR = 3'd3;
    localparam logic [2:0] OFF_MCR = 3'd4;
    localparam logic [2:0] OFF_LSR = 3'd5;
    localparam logic [2:0] OFF_MSR = 3'd6;
    localparam logic [2:0] OFF_SCR = 3'd7;

    localparam logic [7:0] IIR_NONE  = 8'h01;
    localparam logic [7:0] IIR_TX    = 8'h02;
    localparam logic [7:0] IIR_RX    = 8'h04;
    localparam logic [7:0] LSR_RESET = 8'h60;

    localparam int DLAB_BIT = 7;
    localparam int IER_RX_BIT = 0;
    localparam int IER_TX_BIT = 1;
    localparam int LSR_DR_BIT = 0;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] offset;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_level;
        logic       rx_dropped;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/uart_register_interface.sv =====
// Top level of the UART register interface: input channel, core and output buffer.
// Depends on uri_pkg and uri_core.
//
// Usage: each word on the item channel is a bus read, a bus write or a byte
// received from the host. Every accepted word yields exactly one word on the
// result channel, in order. A word is taken on a rising edge with its valid
// high and its stall low.
// An accepted word's result goes into the output register when that is free,
// else into the skid register. Throughput is one word per cycle while item_stall
// is low; register state updates on each accepted word, so the next sees it at once.
// The result side has a two-entry buffer, an output register and a skid
// register. When the receiver stalls, one further word is still accepted into
// the skid register; item_stall then rises until the output register drains.
// Reset clears both buffer entries, loads the register file with its reset
// values (identification 0x01, line status 0x60, all else zero) and lowers
// the interrupt line. No word is lost or repeated under any stall pattern.
`default_nettype none

module uart_register_interface
    import uri_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    logic    accept;
    logic    take;
    logic    out_free;
    result_t core_result;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign take         = out_valid_reg && !result_stall;
    assign out_free     = !out_valid_reg || take;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    uri_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .result (core_result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = core_result;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_next       = core_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_refills_out: assert property (@(posedge clk) disable iff (!rst_n)
        take && skid_valid_reg |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved into output register");

    a_accept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_free |=> out_valid_reg && out_reg == $past(core_result))
        else $error("accepted word did not reach the output register");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/uri_core.sv =====
// Register file, divisor latch and interrupt logic of the UART register interface.
// Updates state on each accepted word and forms its result; depends on uri_pkg.
`default_nettype none

module uri_core
    import uri_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire item_t   item,
    output result_t      result
);

    logic [7:0] rbr_reg, rbr_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] iir_reg, iir_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] lsr_reg, lsr_next;
    logic [7:0] msr_reg, msr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic       irq_reg, irq_next;
    logic       div_hit;

    assign div_hit = lcr_reg[DLAB_BIT] && (item.offset[2:1] == 2'b00);

    always_comb
    begin
        rbr_next = rbr_reg;
        ier_next = ier_reg;
        iir_next = iir_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        lsr_next = lsr_reg;
        msr_next = msr_reg;
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        irq_next = irq_reg;
        result   = '0;

        case (item.operation)
            OP_READ:
            begin
                if (div_hit)
                begin
                    result.read_data = item.offset[0] ? dlm_reg : dll_reg;
                end
                else
                begin
                    case (item.offset)
                        OFF_RBR:
                        begin
                            result.read_data = rbr_reg;
                            lsr_next[LSR_DR_BIT] = 1'b0;
                        end
                        OFF_IER: result.read_data = ier_reg;
                        OFF_IIR:
                        begin
                            result.read_data = iir_reg;
                            if (iir_reg == IIR_RX && ier_reg[IER_TX_BIT])
                            begin
                                iir_next = IIR_TX;
                            end
                            else
                            begin
                                iir_next = IIR_NONE;
                                irq_next = 1'b0;
                            end
                        end
                        OFF_LCR: result.read_data = lcr_reg;
                        OFF_MCR: result.read_data = mcr_reg;
                        OFF_LSR: result.read_data = lsr_reg;
                        OFF_MSR: result.read_data = msr_reg;
                        default: result.read_data = '0;
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (div_hit)
                begin
                    if (item.offset[0])
                    begin
                        dlm_next = item.data;
                    end
                    else
                    begin
                        dll_next = item.data;
                    end
                end
                else
                begin
                    case (item.offset)
                        OFF_RBR:
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = item.data;
                            if (ier_reg[IER_TX_BIT] && iir_reg != IIR_RX)
                            begin
                                iir_next = IIR_TX;
                                irq_next = 1'b1;
                            end
                        end
                        OFF_IER: ier_next = item.data;
                        OFF_LCR: lcr_next = item.data;
                        OFF_MCR: mcr_next = item.data;
                        OFF_LSR: lsr_next = item.data;
                        OFF_MSR: msr_next = item.data;
                        default: ;
                    endcase
                end
            end
            OP_RX:
            begin
                if (lsr_reg[LSR_DR_BIT])
                begin
                    result.rx_dropped = 1'b1;
                end
                else
                begin
                    rbr_next = item.data;
                    lsr_next[LSR_DR_BIT] = 1'b1;
                    if (ier_reg[IER_RX_BIT])
                    begin
                        iir_next = IIR_RX;
                        irq_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        result.irq_level = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbr_reg <= '0;
            ier_reg <= '0;
            iir_reg <= IIR_NONE;
            lcr_reg <= '0;
            mcr_reg <= '0;
            lsr_reg <= LSR_RESET;
            msr_reg <= '0;
            dll_reg <= '0;
            dlm_reg <= '0;
            irq_reg <= 1'b0;
        end
        else if (accept)
        begin
            rbr_reg <= rbr_next;
            ier_reg <= ier_next;
            iir_reg <= iir_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            lsr_reg <= lsr_next;
            msr_reg <= msr_next;
            dll_reg <= dll_next;
            dlm_reg <= dlm_next;
            irq_reg <= irq_next;
        end
    end

    // The interrupt line is high exactly when a cause is pending.
    a_irq_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
        irq_reg == (iir_reg != IIR_NONE))
        else $error("interrupt line disagrees with identification code");

    // A received byte that is dropped leaves the receive buffer untouched.
    a_drop_keeps_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.rx_dropped |=> $stable(rbr_reg))
        else $error("dropped byte changed the receive buffer");

    // A divisor access never transmits.
    a_divisor_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        div_hit |-> !result.tx_valid)
        else $error("divisor latch access transmitted a byte");

endmodule

`default_nettype wire
